/* rtl/ppbg_pkg.sv */
package ppbg_pkg;

   localparam int LANE_COUNT = 4;

   typedef logic [1:0] colour_type;
   typedef logic [LANE_COUNT-1:0][1:0] colour_vec_type;

   typedef struct packed {
      logic [7:0]  pixel_byte;
      logic [12:0] byte_offset;
   } result_type;

   // One period of the wave, quantised to four levels
   localparam colour_type WAVE_TABLE [64] = '{
      2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
      2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
      2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
      2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
      2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
      2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
   };

   // Sum of three wave terms (0 to 9) to colour
   localparam colour_type SHADE_RAMP [10] = '{
      2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3
   };

endpackage

/* rtl/ppbg_if.sv */
interface ppbg_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] column;
   logic [7:0] row;
   logic [7:0] phase_x;
   logic [7:0] phase_row;
   logic [7:0] phase_diag;

   modport source(output valid, column, row, phase_x, phase_row, phase_diag, input ready);
   modport sink(input valid, column, row, phase_x, phase_row, phase_diag, output ready);
endinterface

interface ppbg_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_byte;
   logic [12:0] byte_offset;

   modport source(output valid, pixel_byte, byte_offset, input ready);
   modport sink(input valid, pixel_byte, byte_offset, output ready);
endinterface

/* rtl/plasma_pixel_byte_generator.sv */
// Plasma pixel byte generator.
//
// req_bus carries one bitmap byte position (column, row) and the three wave
// phases of the frame; rsp_bus returns the packed byte of four 2-bit colours
// (leftmost pixel in bits 7:6) and its character-cell bitmap offset.
// Both channels use valid/ready; a beat moves when both are high.
//
// Four pixel lanes evaluate the wave sums of the byte in parallel and a
// packing stage merges their colours into a single output register.
// The response is valid in the cycle after the request beat. Throughput is
// one byte per clock while the receiver is ready, set by the single output
// register that is refilled in the same cycle it is drained.
//
// Reset (synchronous) empties the output register; no other state exists.
// While the receiver stalls, the response is held and req_bus.ready stays
// low until the held beat is taken.
module plasma_pixel_byte_generator #(
   parameter int ROW_BYTES = 40
) (
   input  logic      clock,
   input  logic      reset,
   ppbg_req_if.sink  req_bus,
   ppbg_rsp_if.source rsp_bus
);
   import ppbg_pkg::*;

   localparam logic [12:0] ROW_STRIDE = 13'(ROW_BYTES * 8);

   colour_type     vert_term;
   colour_vec_type colours;
   logic [5:0]     vert_idx;
   logic [12:0]    offset_calc;

   assign vert_idx  = req_bus.row[5:0] + req_bus.phase_row[5:0];
   assign vert_term = WAVE_TABLE[vert_idx];

   // eight rows share a character cell; wrap to the 13-bit field
   assign offset_calc = 13'(req_bus.row[7:3]) * ROW_STRIDE
                      + 13'(req_bus.row[2:0])
                      + {4'b0000, req_bus.column, 3'b000};

   for (genvar k = 0; k < LANE_COUNT; k++) begin : g_lane
      ppbg_lane u_lane (
         .pixel_index ({req_bus.column, 2'(k)}),
         .row         (req_bus.row),
         .phase_x     (req_bus.phase_x),
         .phase_diag  (req_bus.phase_diag),
         .vert_term   (vert_term),
         .colour      (colours[k])
      );
   end

   ppbg_pack u_pack (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .colours     (colours),
      .byte_offset (offset_calc),
      .rsp_bus     (rsp_bus)
   );

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> rsp_bus.valid)
      else $error("accepted request beat produced no response");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request taken while response is stalled");

   a_empty_takes_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("request refused with empty output register");

endmodule

/* rtl/ppbg_lane.sv */
module ppbg_lane (
   input  logic [7:0]           pixel_index,
   input  logic [7:0]           row,
   input  logic [7:0]           phase_x,
   input  logic [7:0]           phase_diag,
   input  ppbg_pkg::colour_type vert_term,
   output ppbg_pkg::colour_type colour
);
   import ppbg_pkg::*;

   logic [8:0] diag_pos;
   logic [5:0] horz_idx;
   logic [5:0] diag_idx;
   logic [3:0] wave_sum;

   assign diag_pos = {1'b0, pixel_index} + {1'b0, row};
   // only the low six bits of the index matter, the table wraps every 64
   assign horz_idx = pixel_index[5:0] + phase_x[5:0];
   assign diag_idx = diag_pos[6:1] + phase_diag[5:0];

   assign wave_sum = {2'b00, WAVE_TABLE[horz_idx]} + {2'b00, vert_term}
                   + {2'b00, WAVE_TABLE[diag_idx]};
   assign colour   = SHADE_RAMP[wave_sum];

endmodule

/* rtl/ppbg_pack.sv */
module ppbg_pack (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  ppbg_pkg::colour_vec_type colours,
   input  logic [12:0]              byte_offset,
   ppbg_rsp_if.source               rsp_bus
);
   import ppbg_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   result_type result_in;

   // take a new beat whenever the output register is empty or being drained
   assign in_ready = !valid_ff || rsp_bus.ready;
   assign valid_in = in_valid || (valid_ff && !rsp_bus.ready);

   always_comb begin
      result_in.byte_offset = byte_offset;
      // lane 0 is the leftmost pixel: top bits
      for (int k = 0; k < LANE_COUNT; k++) begin
         result_in.pixel_byte[7-2*k -: 2] = colours[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.pixel_byte  = result_ff.pixel_byte;
   assign rsp_bus.byte_offset = result_ff.byte_offset;

endmodule
